### rtl/core/cdd_pkg.sv
`timescale 1ns / 1ps

package cdd_pkg;

    localparam int unsigned TYPE_W  = 3;
    localparam int unsigned CNT_W   = 15;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MON_W   = 4;
    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned N_W     = 18;   // count * 7 fits in 18 bits
    localparam int unsigned MOD_W   = 9;    // year mod 400
    localparam int unsigned Q_W     = 8;    // floor(year_bits / 400)
    localparam int unsigned SCALE_W = 10;

    // unit codes
    localparam logic [TYPE_W-1:0] REQ_DAY        = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_WEEK       = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_MONTH      = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_YEAR       = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_DECADE     = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_CENTURY    = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_MILLENNIUM = 3'd6;

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };
    localparam logic [DAY_W-1:0] FEB_LEAP_DAYS = 5'd29;

    localparam logic [MOD_W-1:0]  LEAP_CYCLE  = 9'd400;
    localparam logic [MOD_W-1:0]  WRAP_REM    = 9'd336;  // 65536 mod 400
    localparam logic [MOD_W-1:0]  TOP_REM     = 9'd367;  // 32767 mod 400
    localparam logic [MOD_W-1:0]  CENT_1      = 9'd100;
    localparam logic [MOD_W-1:0]  CENT_2      = 9'd200;
    localparam logic [MOD_W-1:0]  CENT_3      = 9'd300;
    localparam logic [11:0]       MOD_RECIP   = 12'd2622; // ceil(2^16 / 25)
    localparam logic [YEAR_W-1:0] YEAR_MIN    = 16'h8000;

    localparam logic [SCALE_W-1:0] SCALE_YEAR       = 10'd1;
    localparam logic [SCALE_W-1:0] SCALE_DECADE     = 10'd10;
    localparam logic [SCALE_W-1:0] SCALE_CENTURY    = 10'd100;
    localparam logic [SCALE_W-1:0] SCALE_MILLENNIUM = 10'd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_Q,
        ST_MOD_R,
        ST_FIX,
        ST_STEP,
        ST_YMUL,
        ST_YSUB,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MOD_Q,
        OP_MOD_R,
        OP_FIX,
        OP_STEP,
        OP_YMUL,
        OP_YSUB
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
    } t_stat;

    function automatic logic is_leap(input logic [MOD_W-1:0] ymod);
        logic by4;
        by4 = (ymod[1:0] == 2'd0);
        return (ymod == '0) ||
               (by4 && ymod != CENT_1 && ymod != CENT_2 && ymod != CENT_3);
    endfunction

    // month must be 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [MON_W-1:0] idx;
        idx = m - MON_JAN;
        if (m == 4'd2 && leap)
            return FEB_LEAP_DAYS;
        return MONTH_DAYS[idx];
    endfunction

    function automatic logic [SCALE_W-1:0] year_scale(input logic [TYPE_W-1:0] t);
        logic [SCALE_W-1:0] s;
        case (t)
            REQ_YEAR:    s = SCALE_YEAR;
            REQ_DECADE:  s = SCALE_DECADE;
            REQ_CENTURY: s = SCALE_CENTURY;
            default:     s = SCALE_MILLENNIUM;
        endcase
        return s;
    endfunction

endpackage

### rtl/core/cdd_ctrl.sv
`timescale 1ns / 1ps

module cdd_ctrl import cdd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [TYPE_W-1:0] i_req_type,
    input  logic              i_ready,
    input  t_stat             i_stat,
    output logic              o_ready,
    output logic              o_valid,
    output t_cmd              o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        o_ready      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    unique case (i_req_type) inside
                        REQ_DAY, REQ_WEEK, REQ_MONTH:                  n_state = ST_MOD_Q;
                        REQ_YEAR, REQ_DECADE, REQ_CENTURY, REQ_MILLENNIUM: n_state = ST_YMUL;
                        default:                                       n_state = ST_DONE;
                    endcase
                end
            end
            ST_MOD_Q: begin
                o_cmd.op = OP_MOD_Q;
                n_state  = ST_MOD_R;
            end
            ST_MOD_R: begin
                o_cmd.op = OP_MOD_R;
                n_state  = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.op = OP_FIX;
                n_state  = ST_STEP;
            end
            ST_STEP: begin
                if (i_stat.n_zero)
                    n_state = ST_DONE;
                else
                    o_cmd.op = OP_STEP;
            end
            ST_YMUL: begin
                o_cmd.op = OP_YMUL;
                n_state  = ST_YSUB;
            end
            ST_YSUB: begin
                o_cmd.op = OP_YSUB;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load)
            n_out_valid = 1'b1;
        else if (i_ready)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    assign o_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("result register overwritten before transfer");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after an accepted transfer");

    a_done_loads_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_valid)
        else $error("result not presented after load");

endmodule

### rtl/core/cdd_dpath.sv
`timescale 1ns / 1ps

module cdd_dpath import cdd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [TYPE_W-1:0] i_req_type,
    input  logic [CNT_W-1:0]  i_unit_count,
    input  logic [DAY_W-1:0]  i_in_day,
    input  logic [MON_W-1:0]  i_in_month,
    input  logic [YEAR_W-1:0] i_in_year,
    output t_stat             o_stat,
    output logic [DAY_W-1:0]  o_day,
    output logic [MON_W-1:0]  o_month,
    output logic [YEAR_W-1:0] o_year
);

    logic [TYPE_W-1:0] r_type;
    logic [CNT_W-1:0]  r_cnt;
    logic [N_W-1:0]    r_n;
    logic [DAY_W-1:0]  r_d;
    logic [MON_W-1:0]  r_m;
    logic [YEAR_W-1:0] r_y;
    logic [MOD_W-1:0]  r_ymod;
    logic [Q_W-1:0]    r_q;
    logic [YEAR_W-1:0] r_prod;
    logic [DAY_W-1:0]  r_out_d;
    logic [MON_W-1:0]  r_out_m;
    logic [YEAR_W-1:0] r_out_y;

    // year mod 400 from the raw 16-bit pattern
    logic [23:0]       q_prod;
    logic [16:0]       rem0, rem1;
    logic [MOD_W-1:0]  rem_u, ymod_init;

    always_comb begin
        q_prod = 24'(r_y[YEAR_W-1:4]) * 24'(MOD_RECIP);
        rem0   = {1'b0, r_y} - (17'(r_q) * 17'(LEAP_CYCLE));
        rem1   = (rem0 >= 17'(LEAP_CYCLE)) ? rem0 - 17'(LEAP_CYCLE) : rem0;
        rem_u  = rem1[MOD_W-1:0];
        // negative years: subtract 65536 mod 400
        if (!r_y[YEAR_W-1])
            ymod_init = rem_u;
        else if (rem_u >= WRAP_REM)
            ymod_init = rem_u - WRAP_REM;
        else
            ymod_init = rem_u + (LEAP_CYCLE - WRAP_REM);
    end

    // range correction of the start date
    logic [MON_W-1:0] fix_m;
    logic [DAY_W-1:0] fix_len, fix_d;
    logic [N_W-1:0]   cnt_ext, fix_n;

    always_comb begin
        if (r_m == '0)
            fix_m = MON_JAN;
        else if (r_m > MON_DEC)
            fix_m = MON_DEC;
        else
            fix_m = r_m;
        fix_len = month_len(fix_m, is_leap(r_ymod));
        if (r_d == '0)
            fix_d = DAY_W'(1);
        else if (r_d > fix_len)
            fix_d = fix_len;
        else
            fix_d = r_d;
        cnt_ext = N_W'(r_cnt);
        fix_n   = (r_type == REQ_WEEK) ? (cnt_ext << 3) - cnt_ext : cnt_ext;
    end

    // one step back to the previous month; February never coincides with a
    // year change, so the current leap flag serves the new month
    logic [MON_W-1:0]  prev_m;
    logic [YEAR_W-1:0] prev_y;
    logic [MOD_W-1:0]  prev_ymod;
    logic [DAY_W-1:0]  prev_len;
    logic              n_below_d;

    always_comb begin
        if (r_m == MON_JAN) begin
            prev_m = MON_DEC;
            prev_y = r_y - YEAR_W'(1);
            if (r_y == YEAR_MIN)
                prev_ymod = TOP_REM;
            else if (r_ymod == '0)
                prev_ymod = LEAP_CYCLE - MOD_W'(1);
            else
                prev_ymod = r_ymod - MOD_W'(1);
        end else begin
            prev_m    = r_m - MON_W'(1);
            prev_y    = r_y;
            prev_ymod = r_ymod;
        end
        prev_len  = month_len(prev_m, is_leap(r_ymod));
        n_below_d = (r_n < N_W'(r_d));
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_type <= i_req_type;
                r_cnt  <= i_unit_count;
                r_d    <= i_in_day;
                r_m    <= i_in_month;
                r_y    <= i_in_year;
                r_n    <= '0;
            end
            OP_MOD_Q: r_q    <= q_prod[23:16];
            OP_MOD_R: r_ymod <= ymod_init;
            OP_FIX: begin
                r_m <= fix_m;
                r_d <= fix_d;
                r_n <= fix_n;
            end
            OP_STEP: begin
                if (r_type == REQ_MONTH) begin
                    r_n    <= r_n - N_W'(1);
                    r_m    <= prev_m;
                    r_y    <= prev_y;
                    r_ymod <= prev_ymod;
                    r_d    <= (r_d > prev_len) ? prev_len : r_d;
                end else if (n_below_d) begin
                    r_d <= r_d - r_n[DAY_W-1:0];
                    r_n <= '0;
                end else begin
                    r_n    <= r_n - N_W'(r_d);
                    r_m    <= prev_m;
                    r_y    <= prev_y;
                    r_ymod <= prev_ymod;
                    r_d    <= prev_len;
                end
            end
            OP_YMUL: r_prod <= YEAR_W'(25'(r_cnt) * 25'(year_scale(r_type)));
            OP_YSUB: r_y    <= r_y - r_prod;
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_out_d <= r_d;
            r_out_m <= r_m;
            r_out_y <= r_y;
        end
    end

    assign o_stat.n_zero = (r_n == '0);
    assign o_day   = r_out_d;
    assign o_month = r_out_m;
    assign o_year  = r_out_y;

    a_fix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_FIX |=> (r_m >= MON_JAN && r_m <= MON_DEC && r_d != '0))
        else $error("start date out of range after correction");

    a_ymod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_MOD_R || i_cmd.op == OP_STEP) |=> (r_ymod < LEAP_CYCLE))
        else $error("year residue out of range");

    a_step_day_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_STEP |=> (r_d != '0 && r_d <= month_len(r_m, is_leap(r_ymod))))
        else $error("day outside month after step");

endmodule

### rtl/core/calendar_date_decrement_top.sv
`timescale 1ns / 1ps

// channel  | valid   | ready   | payload
// ---------+---------+---------+----------------------------------------------------
// request  | i_valid | o_ready | i_req_type, i_unit_count, i_in_day, i_in_month, i_in_year
// result   | o_valid | i_ready | o_out_day, o_out_month, o_out_year
//
// Day, week and month requests take the year residue mod 400, correct the start date and
// then run the step loop, which steps back a whole month at a time and then takes the
// remainder from the day; month requests step back one month at a time. Year-type requests
// multiply and subtract, and an unused code goes straight to the result. A new request is
// taken while the last result waits in the output register; a finished one holds until that
// register frees. Synchronous active-low reset, no clearing pass.

module calendar_date_decrement_top import cdd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [TYPE_W-1:0]        i_req_type,
    input  logic [CNT_W-1:0]         i_unit_count,
    input  logic [DAY_W-1:0]         i_in_day,
    input  logic [MON_W-1:0]         i_in_month,
    input  logic signed [YEAR_W-1:0] i_in_year,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [DAY_W-1:0]         o_out_day,
    output logic [MON_W-1:0]         o_out_month,
    output logic signed [YEAR_W-1:0] o_out_year
);

    t_cmd              cmd;
    t_stat             stat;
    logic [YEAR_W-1:0] year_q;

    cdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_ready    (i_ready),
        .i_stat     (stat),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .o_cmd      (cmd)
    );

    cdd_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (i_req_type),
        .i_unit_count (i_unit_count),
        .i_in_day     (i_in_day),
        .i_in_month   (i_in_month),
        .i_in_year    (YEAR_W'(unsigned'(i_in_year))),
        .o_stat       (stat),
        .o_day        (o_out_day),
        .o_month      (o_out_month),
        .o_year       (year_q)
    );

    assign o_out_year = signed'(year_q);

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import cdd_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_UNUSED = 3'd7;
    localparam int N_DIRECTED = 26;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [TYPE_W-1:0]        kind;
        logic [CNT_W-1:0]         count;
        logic [DAY_W-1:0]         day;
        logic [MON_W-1:0]         month;
        logic signed [YEAR_W-1:0] year;
    } t_req;

    typedef struct packed {
        logic [DAY_W-1:0]         day;
        logic [MON_W-1:0]         month;
        logic signed [YEAR_W-1:0] year;
    } t_date;

    typedef struct packed {
        t_req  req;
        logic  typed;
        t_date want;
    } t_row;

    // typed rows carry their answer, the rest go through date_back()
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{REQ_DAY, 15'd0, 5'd15, 4'd6, 16'sd2024}, 1'b1, '{5'd15, 4'd6, 16'sd2024}},
        '{'{REQ_DAY, 15'd1, 5'd1, 4'd1, 16'sd2024}, 1'b1, '{5'd31, 4'd12, 16'sd2023}},
        '{'{REQ_DAY, 15'd1, 5'd1, 4'd3, 16'sd2024}, 1'b1, '{5'd29, 4'd2, 16'sd2024}},
        '{'{REQ_DAY, 15'd1, 5'd1, 4'd3, 16'sd2023}, 1'b1, '{5'd28, 4'd2, 16'sd2023}},
        '{'{REQ_DAY, 15'd1, 5'd1, 4'd3, 16'sd2000}, 1'b1, '{5'd29, 4'd2, 16'sd2000}},
        '{'{REQ_DAY, 15'd1, 5'd1, 4'd3, 16'sd1900}, 1'b1, '{5'd28, 4'd2, 16'sd1900}},
        '{'{REQ_DAY, 15'd1, 5'd1, 4'd3, -16'sd4}, 1'b1, '{5'd29, 4'd2, -16'sd4}},
        '{'{REQ_DAY, 15'd1, 5'd1, 4'd3, -16'sd100}, 1'b1, '{5'd28, 4'd2, -16'sd100}},
        '{'{REQ_DAY, 15'd1, 5'd1, 4'd3, -16'sd400}, 1'b1, '{5'd29, 4'd2, -16'sd400}},
        '{'{REQ_DAY, 15'd0, 5'd0, 4'd0, 16'sd100}, 1'b1, '{5'd1, 4'd1, 16'sd100}},
        '{'{REQ_DAY, 15'd32767, 5'd0, 4'd0, YEAR_MIN}, 1'b0, '0},
        '{'{REQ_WEEK, 15'd1, 5'd8, 4'd1, 16'sd2024}, 1'b1, '{5'd1, 4'd1, 16'sd2024}},
        '{'{REQ_WEEK, 15'd0, 5'd31, 4'd2, 16'sd2023}, 1'b1, '{5'd28, 4'd2, 16'sd2023}},
        '{'{REQ_WEEK, 15'd32767, 5'd31, 4'd12, 16'sd32767}, 1'b0, '0},
        '{'{REQ_MONTH, 15'd1, 5'd31, 4'd3, 16'sd2023}, 1'b1, '{5'd28, 4'd2, 16'sd2023}},
        '{'{REQ_MONTH, 15'd1, 5'd15, 4'd1, YEAR_MIN}, 1'b1, '{5'd15, 4'd12, 16'sd32767}},
        '{'{REQ_MONTH, 15'd0, 5'd31, 4'd4, 16'sd2023}, 1'b1, '{5'd30, 4'd4, 16'sd2023}},
        '{'{REQ_MONTH, 15'd32767, 5'd31, 4'd15, 16'sd0}, 1'b0, '0},
        '{'{REQ_YEAR, 15'd1, 5'd29, 4'd2, 16'sd2024}, 1'b1, '{5'd29, 4'd2, 16'sd2023}},
        '{'{REQ_YEAR, 15'd0, 5'd0, 4'd0, 16'sd77}, 1'b1, '{5'd0, 4'd0, 16'sd77}},
        '{'{REQ_YEAR, 15'd32767, 5'd31, 4'd15, 16'sd0}, 1'b1, '{5'd31, 4'd15, -16'sd32767}},
        '{'{REQ_DECADE, 15'd3, 5'd0, 4'd0, YEAR_MIN}, 1'b1, '{5'd0, 4'd0, 16'sd32738}},
        '{'{REQ_CENTURY, 15'd32767, 5'd5, 4'd5, 16'sd1000}, 1'b0, '0},
        '{'{REQ_MILLENNIUM, 15'd1, 5'd1, 4'd1, 16'sd500}, 1'b1, '{5'd1, 4'd1, -16'sd500}},
        '{'{REQ_MILLENNIUM, 15'd32767, 5'd31, 4'd12, -16'sd1}, 1'b0, '0},
        '{'{REQ_UNUSED, 15'd123, 5'd31, 4'd15, -16'sd5}, 1'b1, '{5'd31, 4'd15, -16'sd5}}
    };

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [TYPE_W-1:0]        i_req_type = '0;
    logic [CNT_W-1:0]         i_unit_count = '0;
    logic [DAY_W-1:0]         i_in_day = '0;
    logic [MON_W-1:0]         i_in_month = '0;
    logic signed [YEAR_W-1:0] i_in_year = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [DAY_W-1:0]         o_out_day;
    logic [MON_W-1:0]         o_out_month;
    logic signed [YEAR_W-1:0] o_out_year;

    t_date pending_dates [$];
    t_date oldest_date;
    int    n_mismatch = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;

    calendar_date_decrement_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_unit_count (i_unit_count),
        .i_in_day     (i_in_day),
        .i_in_month   (i_in_month),
        .i_in_year    (i_in_year),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_day    (o_out_day),
        .o_out_month  (o_out_month),
        .o_out_year   (o_out_year)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int days_in_month(input logic [YEAR_W-1:0] ybits, input int m);
        int  y;
        logic leap;
        y = int'($signed(ybits));
        leap = (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
        if (m == 2)
            return leap ? int'(FEB_LEAP_DAYS) : int'(MONTH_DAYS[1]);
        return int'(MONTH_DAYS[m - 1]);
    endfunction

    function automatic t_date date_back(input t_req r);
        int               d;
        int               m;
        int               n;
        int               len;
        int               scale;
        logic [YEAR_W-1:0] y;
        t_date            res;
        d = int'(r.day);
        m = int'(r.month);
        y = r.year;
        if (r.kind <= REQ_MONTH) begin
            // day/week/month modes normalize the start date first
            if (m < 1) m = 1;
            if (m > 12) m = 12;
            len = days_in_month(y, m);
            if (d < 1) d = 1;
            if (d > len) d = len;
            if (r.kind != REQ_MONTH) begin
                n = (r.kind == REQ_WEEK) ? int'(r.count) * 7 : int'(r.count);
                while (n > 0) begin
                    if (n < d) begin
                        d -= n;
                        n = 0;
                    end else begin
                        n -= d;
                        if (m == 1) begin
                            m = 12;
                            y = y - YEAR_W'(1);
                        end else begin
                            m--;
                        end
                        d = days_in_month(y, m);
                    end
                end
            end else begin
                for (int i = 0; i < int'(r.count); i++) begin
                    if (m == 1) begin
                        m = 12;
                        y = y - YEAR_W'(1);
                    end else begin
                        m--;
                    end
                    len = days_in_month(y, m);
                    if (d > len) d = len;
                end
            end
        end else if (r.kind != REQ_UNUSED) begin
            case (r.kind)
                REQ_YEAR:    scale = int'(SCALE_YEAR);
                REQ_DECADE:  scale = int'(SCALE_DECADE);
                REQ_CENTURY: scale = int'(SCALE_CENTURY);
                default:     scale = int'(SCALE_MILLENNIUM);
            endcase
            y = y - YEAR_W'(int'(r.count) * scale);
        end
        res.day = DAY_W'(d);
        res.month = MON_W'(m);
        res.year = y;
        return res;
    endfunction

    task automatic send_request(input t_req r, input t_date want);
        i_valid      <= 1'b1;
        i_req_type   <= r.kind;
        i_unit_count <= r.count;
        i_in_day     <= r.day;
        i_in_month   <= r.month;
        i_in_year    <= r.year;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_dates.push_back(want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_dates.size() == 0) begin
                $display("%0t: unexpected result transfer: day %0d month %0d year %0d",
                         $time, o_out_day, o_out_month, o_out_year);
                n_mismatch++;
            end else begin
                oldest_date = pending_dates.pop_front();
                if (o_out_day !== oldest_date.day) begin
                    $display("%0t: day mismatch: expected %0d, got %0d",
                             $time, oldest_date.day, o_out_day);
                    n_mismatch++;
                end
                if (o_out_month !== oldest_date.month) begin
                    $display("%0t: month mismatch: expected %0d, got %0d",
                             $time, oldest_date.month, o_out_month);
                    n_mismatch++;
                end
                if (o_out_year !== oldest_date.year) begin
                    $display("%0t: year mismatch: expected %0d, got %0d",
                             $time, oldest_date.year, o_out_year);
                    n_mismatch++;
                end
            end
        end
    end

    initial begin
        t_req r;
        t_date want;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 57;
        for (int k = 0; k < N_DIRECTED; k++) begin
            r = DIRECTED_ROWS[k].req;
            want = DIRECTED_ROWS[k].typed ? DIRECTED_ROWS[k].want : date_back(r);
            send_request(r, want);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 27 : 0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r.kind = ($urandom_range(15) == 0) ? REQ_UNUSED
                                                   : TYPE_W'($urandom_range(6));
                // long counts are slow in day/week/month modes, keep them rare
                case ($urandom_range(7))
                    0:       r.count = CNT_W'($urandom_range(32767));
                    1, 2, 3: r.count = CNT_W'($urandom_range(7));
                    default: r.count = CNT_W'($urandom_range(60));
                endcase
                r.day = ($urandom_range(7) == 0) ? DAY_W'($urandom_range(31))
                                                 : DAY_W'($urandom_range(1, 31));
                r.month = ($urandom_range(7) == 0) ? MON_W'($urandom_range(15))
                                                   : MON_W'($urandom_range(1, 12));
                case ($urandom_range(3))
                    0:       r.year = YEAR_W'($urandom_range(1582, 2400));
                    // across the wrap
                    1:       r.year = YEAR_W'(32'h7FD8 + $urandom_range(80));
                    2:       r.year = YEAR_W'($urandom_range(80) - 40);
                    default: r.year = YEAR_W'($urandom);
                endcase
                send_request(r, date_back(r));
            end
        end
        i_valid <= 1'b0;

        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(200_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
